// ----- rtl/rsp_pkg.sv -----
// Shared types, constants and helper functions for the rotate/scale pixel
// address generator. No dependencies.
package rsp_pkg;

  localparam int SIZE_W    = 11;
  localparam int COORD_W   = 10;
  localparam int NUM_W     = 21;
  localparam int IDX_W     = 20;
  localparam int ROT_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int LIM_W     = 13;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT    = 3'd4;

  localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] dw;
    logic [SIZE_W-1:0] dh;
    logic [SIZE_W-1:0] sw;
    logic [SIZE_W-1:0] sh;
    logic [ROT_W-1:0]  rot;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] ny;
  } prod_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rem;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  quo;
  } div_t;

  // Zero reads as one, anything above the limit reads as the limit.
  function automatic logic [SIZE_W-1:0] fit_size(logic [SIZE_W-1:0] v,
                                                 logic [LIM_W-1:0] lim);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if ({{(LIM_W-SIZE_W){1'b0}}, v} > lim) begin
      res = lim[SIZE_W-1:0];
    end
    return res;
  endfunction

  // One restoring-division step: bring down the next numerator bit.
  function automatic div_t div_step(div_t s, logic [SIZE_W-1:0] d);
    div_t            o;
    logic [SIZE_W:0] trial;
    trial = {s.rem, s.num[NUM_W-1]};
    o.num = {s.num[NUM_W-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      o.rem = SIZE_W'(trial - {1'b0, d});
      o.quo = {s.quo[NUM_W-2:0], 1'b1};
    end else begin
      o.rem = trial[SIZE_W-1:0];
      o.quo = {s.quo[NUM_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- rtl/rotate_scale_pixel_address.sv -----
// Top level of the rotate/scale pixel address generator.
// Depends on rsp_pkg, rsp_front, rsp_fifo and rsp_back.
//
// Usage:
//  - Input channel (in_valid / in_stall): one destination pixel (in_dest_x,
//    in_dest_y) per transaction. Output channel (out_valid / out_stall): the
//    source column, row and linear index for that pixel, one transaction per
//    input, in order.
//  - Configuration: write cfg_wdata to register cfg_index while cfg_we is
//    high: 0 dest width, 1 dest height, 2 source width, 3 source height,
//    4 rotation in quarter turns. Sizes are fitted into 1..MAX on write.
//    Write only while the pipeline is empty.
//  - Throughput: one transaction per cycle while the receiver does not stall.
//    Path from input to output: product stage, queue, 21 divide stages of one
//    quotient bit each, rotate/clamp stage, index stage.
//  - Reset (rst_n low, synchronous): pipeline and queue empty, registers
//    back to 240 x 320 destination, 320 x 240 source, no rotation.
//  - Receiver stall: the back pipeline holds; the four-entry queue absorbs
//    the front stage; in_stall rises when the queue is full and a pixel waits.
module rotate_scale_pixel_address #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsp_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rsp_pkg::COORD_W-1:0]   in_dest_x,
  input  logic [rsp_pkg::COORD_W-1:0]   in_dest_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsp_pkg::COORD_W-1:0]   out_source_x,
  output logic [rsp_pkg::COORD_W-1:0]   out_source_y,
  output logic [rsp_pkg::IDX_W-1:0]     out_source_index
);
  import rsp_pkg::*;

  localparam logic [LIM_W-1:0] LIM_W_MAX = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] LIM_H_MAX = LIM_W'(MAX_HEIGHT);

  cfg_t  cfg_r;
  logic  push;
  prod_t push_data;
  logic  q_full;
  logic  q_not_empty;
  prod_t q_data;
  logic  pop;

  // Fit sizes on write so the datapath always sees legal values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dw  <= SIZE_W'(240);
      cfg_r.dh  <= SIZE_W'(320);
      cfg_r.sw  <= SIZE_W'(320);
      cfg_r.sh  <= SIZE_W'(240);
      cfg_r.rot <= ROT_NONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_W: cfg_r.dw  <= fit_size(cfg_wdata, LIM_W_MAX);
        REG_DEST_H: cfg_r.dh  <= fit_size(cfg_wdata, LIM_H_MAX);
        REG_SRC_W:  cfg_r.sw  <= fit_size(cfg_wdata, LIM_W_MAX);
        REG_SRC_H:  cfg_r.sh  <= fit_size(cfg_wdata, LIM_H_MAX);
        REG_ROT:    cfg_r.rot <= cfg_wdata[ROT_W-1:0];
        default:    ;  // drop writes to unused indexes
      endcase
    end
  end

  rsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_dest_x (in_dest_x),
    .in_dest_y (in_dest_y),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rsp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  rsp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_not_empty      (q_not_empty),
    .q_data           (q_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_source_x     (out_source_x),
    .out_source_y     (out_source_y),
    .out_source_index (out_source_index)
  );

endmodule

// ----- rtl/rsp_front.sv -----
// Front stage: accept a destination coordinate and form the scaled products.
// Depends on rsp_pkg.
module rsp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rsp_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rsp_pkg::COORD_W-1:0]   in_dest_x,
  input  logic [rsp_pkg::COORD_W-1:0]   in_dest_y,
  output logic                          push,
  output rsp_pkg::prod_t                push_data,
  input  logic                          q_full
);
  import rsp_pkg::*;

  logic              vld_r;
  prod_t             prod_r;
  logic              adv;
  logic              quarter;
  logic [SIZE_W-1:0] rw;
  logic [SIZE_W-1:0] rh;

  assign quarter  = (cfg.rot == ROT_90) || (cfg.rot == ROT_270);
  assign rw       = quarter ? cfg.sh : cfg.sw;
  assign rh       = quarter ? cfg.sw : cfg.sh;
  assign adv      = !vld_r || !q_full;
  assign in_stall = !adv;
  assign push     = vld_r && !q_full;
  assign push_data = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      prod_r.nx <= NUM_W'(in_dest_x) * NUM_W'(rw);
      prod_r.ny <= NUM_W'(in_dest_y) * NUM_W'(rh);
    end
  end

endmodule

// ----- rtl/rsp_fifo.sv -----
// Short queue between the front and back stages.
// Depends on rsp_pkg.
module rsp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rsp_pkg::prod_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rsp_pkg::prod_t pop_data
);
  import rsp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  prod_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W:0]   cnt_r;

  assign full      = (cnt_r == (PTR_W+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(DEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/rsp_back.sv -----
// Back stage: pipelined divide, rotation, clamp and linear index.
// Depends on rsp_pkg.
module rsp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsp_pkg::cfg_t               cfg,
  input  logic                        q_not_empty,
  input  rsp_pkg::prod_t              q_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rsp_pkg::COORD_W-1:0] out_source_x,
  output logic [rsp_pkg::COORD_W-1:0] out_source_y,
  output logic [rsp_pkg::IDX_W-1:0]   out_source_index
);
  import rsp_pkg::*;

  logic              en;
  logic              dvld_r [NUM_W];
  div_t              dx_r   [NUM_W];
  div_t              dy_r   [NUM_W];
  div_t              dx_in  [NUM_W];
  div_t              dy_in  [NUM_W];
  logic              pvld_r;
  logic [SIZE_W-1:0] sx_r;
  logic [SIZE_W-1:0] sy_r;
  logic              ovld_r;
  logic [SIZE_W-1:0] osx_r;
  logic [SIZE_W-1:0] osy_r;
  logic [IDX_W-1:0]  oidx_r;
  logic signed [NUM_W+1:0] rx;
  logic signed [NUM_W+1:0] ry;
  logic signed [NUM_W+1:0] swm1;
  logic signed [NUM_W+1:0] shm1;
  logic signed [NUM_W+1:0] sx_raw;
  logic signed [NUM_W+1:0] sy_raw;
  logic [SIZE_W-1:0] sx_c;
  logic [SIZE_W-1:0] sy_c;

  assign en  = !ovld_r || !out_stall;
  assign pop = en && q_not_empty;

  // Divide stages: one quotient bit per stage, both axes side by side.
  genvar s;
  generate
    for (s = 0; s < NUM_W; s++) begin : g_div
      if (s == 0) begin : g_first
        assign dx_in[s] = '{rem: '0, num: q_data.nx, quo: '0};
        assign dy_in[s] = '{rem: '0, num: q_data.ny, quo: '0};
        always_ff @(posedge clk) begin
          if (!rst_n) dvld_r[s] <= 1'b0;
          else if (en) dvld_r[s] <= q_not_empty;
        end
      end else begin : g_next
        assign dx_in[s] = dx_r[s-1];
        assign dy_in[s] = dy_r[s-1];
        always_ff @(posedge clk) begin
          if (!rst_n) dvld_r[s] <= 1'b0;
          else if (en) dvld_r[s] <= dvld_r[s-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dx_r[s] <= div_step(dx_in[s], cfg.dw);
          dy_r[s] <= div_step(dy_in[s], cfg.dh);
        end
      end
    end
  endgenerate

  // Rotate, then clamp into the source frame.
  assign rx   = $signed({2'b00, dx_r[NUM_W-1].quo});
  assign ry   = $signed({2'b00, dy_r[NUM_W-1].quo});
  assign swm1 = $signed((NUM_W+2)'(cfg.sw) - (NUM_W+2)'(1));
  assign shm1 = $signed((NUM_W+2)'(cfg.sh) - (NUM_W+2)'(1));

  always_comb begin
    unique case (cfg.rot)
      ROT_90: begin
        sx_raw = ry;
        sy_raw = shm1 - rx;
      end
      ROT_180: begin
        sx_raw = swm1 - rx;
        sy_raw = shm1 - ry;
      end
      ROT_270: begin
        sx_raw = swm1 - ry;
        sy_raw = rx;
      end
      default: begin
        sx_raw = rx;
        sy_raw = ry;
      end
    endcase
    if (sx_raw < 0)         sx_c = '0;
    else if (sx_raw > swm1) sx_c = swm1[SIZE_W-1:0];
    else                    sx_c = sx_raw[SIZE_W-1:0];
    if (sy_raw < 0)         sy_c = '0;
    else if (sy_raw > shm1) sy_c = shm1[SIZE_W-1:0];
    else                    sy_c = sy_raw[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else if (en) begin
      pvld_r <= dvld_r[NUM_W-1];
      ovld_r <= pvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r   <= sx_c;
      sy_r   <= sy_c;
      osx_r  <= sx_r;
      osy_r  <= sy_r;
      oidx_r <= IDX_W'(sy_r * cfg.sw + {{SIZE_W{1'b0}}, sx_r});
    end
  end

  assign out_valid        = ovld_r;
  assign out_source_x     = osx_r[COORD_W-1:0];
  assign out_source_y     = osy_r[COORD_W-1:0];
  assign out_source_index = oidx_r;

  a_x_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> (osx_r < cfg.sw)) else $error("source column outside frame");
  a_y_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> (osy_r < cfg.sh)) else $error("source row outside frame");
  a_div_to_post: assert property (@(posedge clk) disable iff (!rst_n)
    (en && dvld_r[NUM_W-1]) |=> pvld_r) else $error("divider result lost");

endmodule
